// ===== src/cav_pkg.sv =====
// ----------------------------------------------------------------------------
// cav_pkg: shared types and constants of the clockwise angle unit
// Holds the fixed-point formats, the angle constants and the arctangent
// table of the CORDIC vectoring chain.
// ----------------------------------------------------------------------------
package cav_pkg;

   // Scaled coordinates stay below 2^61 in magnitude, including the CORDIC gain.
   localparam int DATA_WIDTH  = 62;
   // Before the CORDIC gain, scaled coordinates stay below 2^SCALE_TOP in magnitude.
   localparam int SCALE_TOP   = 60;
   // Angle accumulator in Q3.29, signed, with headroom for the wrap.
   localparam int ANGLE_WIDTH = 34;
   localparam int RESULT_WIDTH = 32;
   localparam int MAX_CELLS   = 32;

   typedef logic signed [DATA_WIDTH-1:0]  coord_type;
   typedef logic signed [ANGLE_WIDTH-1:0] angle_type;

   localparam angle_type ANG_ZERO     = 34'sd0;
   localparam angle_type ANG_HALF_PI  = 34'sd843314857;
   localparam angle_type ANG_PI       = 34'sd1686629713;
   localparam angle_type ANG_3HALF_PI = 34'sd2529944570;
   localparam angle_type ANG_TWO_PI   = 34'sd3373259426;

   typedef struct packed {
      coord_type x;
      coord_type y;
      angle_type z;
      logic      on_axis;
      angle_type axis_angle;
   } stage_type;

   function automatic angle_type atan_q29(input int unsigned idx);
      angle_type value;
      case (idx)
         0:  value = 34'sd421657428;
         1:  value = 34'sd248918915;
         2:  value = 34'sd131521918;
         3:  value = 34'sd66762579;
         4:  value = 34'sd33510843;
         5:  value = 34'sd16771758;
         6:  value = 34'sd8387925;
         7:  value = 34'sd4194219;
         8:  value = 34'sd2097141;
         9:  value = 34'sd1048575;
         10: value = 34'sd524288;
         11: value = 34'sd262144;
         12: value = 34'sd131072;
         13: value = 34'sd65536;
         14: value = 34'sd32768;
         15: value = 34'sd16384;
         16: value = 34'sd8192;
         17: value = 34'sd4096;
         18: value = 34'sd2048;
         19: value = 34'sd1024;
         20: value = 34'sd512;
         21: value = 34'sd256;
         22: value = 34'sd128;
         23: value = 34'sd64;
         24: value = 34'sd32;
         25: value = 34'sd16;
         26: value = 34'sd8;
         27: value = 34'sd4;
         28: value = 34'sd2;
         29: value = 34'sd1;
         default: value = ANG_ZERO;
      endcase
      return value;
   endfunction

endpackage

// ===== src/clockwise_angle_of_vector_unit.sv =====
// ----------------------------------------------------------------------------
// clockwise_angle_of_vector_unit: clockwise angle of a vector by CORDIC
// Returns the clockwise angle in [0, 2*pi), unsigned Q3.29 radians, that
// turns the positive x axis onto the vector (x, y).
//
//   Channel  Direction  Handshake           Payload
//   req      in         req_valid/req_stall req_x_coord, req_y_coord
//   rsp      out        rsp_valid/rsp_stall rsp_angle_rad
//
// One transaction is accepted per cycle while req_stall is low; each result
// passes the input stage, one cell per micro-rotation and the output stage.
// Every stage holds its own transaction.
// Reset empties the chain. A stall on rsp backs up only as far as the first
// empty stage, so gaps in the chain are closed while the output waits.
// ----------------------------------------------------------------------------
module clockwise_angle_of_vector_unit
   import cav_pkg::*;
#(
   parameter int COORD_WIDTH = 24,
   parameter int ITERATIONS  = 24
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [COORD_WIDTH-1:0]  req_x_coord,
   input  logic signed [COORD_WIDTH-1:0]  req_y_coord,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic        [RESULT_WIDTH-1:0] rsp_angle_rad
);

   localparam int NUM_CELLS = (ITERATIONS < MAX_CELLS) ? ITERATIONS : MAX_CELLS;

   logic      chain_valid [0:NUM_CELLS];
   logic      chain_ready [0:NUM_CELLS];
   stage_type chain_data  [0:NUM_CELLS];
   logic      prep_ready;

   logic                    rsp_valid_ff;
   logic [RESULT_WIDTH-1:0] angle_ff;
   logic [RESULT_WIDTH-1:0] angle_in;
   angle_type               negated;
   angle_type               wrapped;

   cav_prep #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (prep_ready),
      .in_x      (req_x_coord),
      .in_y      (req_y_coord),
      .out_valid (chain_valid[0]),
      .out_ready (chain_ready[0]),
      .out_data  (chain_data[0])
   );

   for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
      cav_cell #(
         .STAGE (k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[k]),
         .in_ready  (chain_ready[k]),
         .in_data   (chain_data[k]),
         .out_valid (chain_valid[k+1]),
         .out_ready (chain_ready[k+1]),
         .out_data  (chain_data[k+1])
      );
   end

   assign req_stall              = !prep_ready;
   assign chain_ready[NUM_CELLS] = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      negated = -chain_data[NUM_CELLS].z;
      wrapped = negated[ANGLE_WIDTH-1] ? (negated + ANG_TWO_PI) : negated;
      if (chain_data[NUM_CELLS].on_axis) begin
         angle_in = chain_data[NUM_CELLS].axis_angle[RESULT_WIDTH-1:0];
      end else if (wrapped[ANGLE_WIDTH-1]) begin
         angle_in = '0;
      end else if (wrapped >= ANG_TWO_PI) begin
         angle_in = RESULT_WIDTH'(ANG_TWO_PI - 34'sd1);
      end else begin
         angle_in = wrapped[RESULT_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (chain_ready[NUM_CELLS]) begin
         rsp_valid_ff <= chain_valid[NUM_CELLS];
      end
   end

   always_ff @(posedge clock) begin
      if (chain_ready[NUM_CELLS] && chain_valid[NUM_CELLS]) begin
         angle_ff <= angle_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_angle_rad = angle_ff;

endmodule

// ===== src/cav_prep.sv =====
// ----------------------------------------------------------------------------
// cav_prep: input stage of the clockwise angle unit
// Detects vectors on an axis, scales the coordinates and turns vectors in
// the left half-plane into the right half-plane by a quarter turn.
// ----------------------------------------------------------------------------
module cav_prep
   import cav_pkg::*;
#(
   parameter int COORD_WIDTH = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [COORD_WIDTH-1:0] in_x,
   input  logic signed [COORD_WIDTH-1:0] in_y,
   output logic                          out_valid,
   input  logic                          out_ready,
   output stage_type                     out_data
);

   localparam int SHIFT = SCALE_TOP - COORD_WIDTH;

   logic      valid_ff;
   stage_type data_ff;
   stage_type data_in;
   coord_type x_scaled;
   coord_type y_scaled;
   logic      x_zero;
   logic      y_zero;

   assign x_scaled = coord_type'(in_x) <<< SHIFT;
   assign y_scaled = coord_type'(in_y) <<< SHIFT;
   assign x_zero   = (in_x == '0);
   assign y_zero   = (in_y == '0);

   always_comb begin
      data_in            = '0;
      data_in.on_axis    = x_zero || y_zero;
      data_in.axis_angle = ANG_ZERO;
      if (x_zero) begin
         if (in_y[COORD_WIDTH-1]) begin
            data_in.axis_angle = ANG_HALF_PI;
         end else if (!y_zero) begin
            data_in.axis_angle = ANG_3HALF_PI;
         end
      end else if (y_zero) begin
         if (in_x[COORD_WIDTH-1]) begin
            data_in.axis_angle = ANG_PI;
         end
      end else if (in_x[COORD_WIDTH-1]) begin
         if (!in_y[COORD_WIDTH-1]) begin
            data_in.x = y_scaled;
            data_in.y = -x_scaled;
            data_in.z = ANG_HALF_PI;
         end else begin
            data_in.x = -y_scaled;
            data_in.y = x_scaled;
            data_in.z = -ANG_HALF_PI;
         end
      end else begin
         data_in.x = x_scaled;
         data_in.y = y_scaled;
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== src/cav_cell.sv =====
// ----------------------------------------------------------------------------
// cav_cell: one CORDIC vectoring micro-rotation
// Rotates the vector towards the x axis by a fixed arctangent step and
// accumulates the angle turned, then hands the result to the next cell.
// ----------------------------------------------------------------------------
module cav_cell
   import cav_pkg::*;
#(
   parameter int STAGE = 0
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  stage_type in_data,
   output logic      out_valid,
   input  logic      out_ready,
   output stage_type out_data
);

   localparam angle_type ATAN_STEP = atan_q29(STAGE);

   logic      valid_ff;
   stage_type data_ff;
   stage_type data_in;
   coord_type dx;
   coord_type dy;

   assign dx = in_data.y >>> STAGE;
   assign dy = in_data.x >>> STAGE;

   always_comb begin
      data_in = in_data;
      if (!in_data.y[DATA_WIDTH-1]) begin
         data_in.x = in_data.x + dx;
         data_in.y = in_data.y - dy;
         data_in.z = in_data.z + ATAN_STEP;
      end else begin
         data_in.x = in_data.x - dx;
         data_in.y = in_data.y + dy;
         data_in.z = in_data.z - ATAN_STEP;
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench of the clockwise angle unit
// Sends signed vectors, starting with the axis cases, the coordinate extremes
// and each quadrant, then random vectors in bursts. Both sides idle and stall
// at random. Every result is checked against an expected angle. That angle
// comes from a CORDIC vectoring calculation done in 64-bit integers in the
// testbench.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import cav_pkg::*;

   localparam int COORD_WIDTH  = 24;
   localparam int ITERATIONS   = 24;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int BURST_COUNT  = 5;
   localparam int BURST_LENGTH = 290;

   typedef logic signed [COORD_WIDTH-1:0] tb_coord_type;
   typedef struct packed {
      tb_coord_type x;
      tb_coord_type y;
   } vector_type;

   localparam tb_coord_type COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
   localparam tb_coord_type COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   tb_coord_type            req_x_coord = '0;
   tb_coord_type            req_y_coord = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [RESULT_WIDTH-1:0] rsp_angle_rad;

   longint arctan_q29 [32] = '{
      421657428, 248918915, 131521918, 66762579,
      33510843, 16771758, 8387925, 4194219,
      2097141, 1048575, 524288, 262144,
      131072, 65536, 32768, 16384,
      8192, 4096, 2048, 1024,
      512, 256, 128, 64,
      32, 16, 8, 4,
      2, 1, 0, 0
   };

   vector_type              vectors_pending [$];
   logic [RESULT_WIDTH-1:0] angles_expected [$];
   logic [RESULT_WIDTH-1:0] angle_due;
   logic                    req_taken = 1'b0;
   int                      results_seen = 0;
   int                      vectors_queued = 0;
   int                      mismatch_count = 0;
   int                      cycle_count = 0;
   int                      send_gap = 0;
   int                      sender_calm = 0;
   int                      stall_left = 0;
   int                      receiver_calm = 0;

   clockwise_angle_of_vector_unit #(
      .COORD_WIDTH(COORD_WIDTH),
      .ITERATIONS (ITERATIONS)
   ) uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_x_coord  (req_x_coord),
      .req_y_coord  (req_y_coord),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_angle_rad(rsp_angle_rad)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [RESULT_WIDTH-1:0] clockwise_angle(input tb_coord_type xc,
                                                               input tb_coord_type yc);
      longint xs;
      longint ys;
      longint zs;
      longint dx;
      longint dy;
      longint tmp;
      longint ang;
      int     i;
      xs = xc;
      ys = yc;
      zs = 0;
      if (xs == 0) begin
         if (ys < 0) ang = ANG_HALF_PI;
         else if (ys > 0) ang = ANG_3HALF_PI;
         else ang = 0;
      end else if (ys == 0) begin
         ang = (xs > 0) ? 0 : longint'(ANG_PI);
      end else begin
         xs = xs <<< (60 - COORD_WIDTH);
         ys = ys <<< (60 - COORD_WIDTH);
         if (xs < 0) begin
            tmp = xs;
            if (ys >= 0) begin
               xs = ys;
               ys = -tmp;
               zs = ANG_HALF_PI;
            end else begin
               xs = -ys;
               ys = tmp;
               zs = -longint'(ANG_HALF_PI);
            end
         end
         for (i = 0; i < ITERATIONS && i < 32; i++) begin
            dx = ys >>> i;
            dy = xs >>> i;
            if (ys >= 0) begin
               xs = xs + dx;
               ys = ys - dy;
               zs = zs + arctan_q29[i];
            end else begin
               xs = xs - dx;
               ys = ys + dy;
               zs = zs - arctan_q29[i];
            end
         end
         ang = -zs;
         if (ang < 0) ang = ang + ANG_TWO_PI;
         if (ang >= ANG_TWO_PI) ang = ANG_TWO_PI - 1;
         if (ang < 0) ang = 0;
      end
      return ang[RESULT_WIDTH-1:0];
   endfunction

   function automatic int idle_length();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 14) return 0;
      else if (pick < 18) return $urandom_range(1, 3);
      else if (pick < 19) return $urandom_range(4, 12);
      else return $urandom_range(20, 60);
   endfunction

   function automatic vector_type random_vector();
      vector_type   v;
      tb_coord_type edge_values [5];
      edge_values = '{COORD_MIN, COORD_MAX, -1, 1, 0};
      v.x = tb_coord_type'($urandom);
      v.y = tb_coord_type'($urandom);
      case ($urandom_range(0, 9))
         4: begin
            v.x = tb_coord_type'($urandom_range(0, 16) - 8);
            v.y = tb_coord_type'($urandom_range(0, 16) - 8);
         end
         5: begin
            if ($urandom_range(0, 1)) v.x = '0;
            else v.y = '0;
         end
         6: begin
            if ($urandom_range(0, 1)) v.x = tb_coord_type'($urandom_range(0, 4) - 2);
            else v.y = tb_coord_type'($urandom_range(0, 4) - 2);
         end
         7: begin
            v.x = edge_values[$urandom_range(0, 4)];
            v.y = edge_values[$urandom_range(0, 4)];
         end
         8: v.y = $urandom_range(0, 1) ? v.x : -v.x;
         default: ;
      endcase
      return v;
   endfunction

   task automatic queue_vector(input tb_coord_type xc, input tb_coord_type yc);
      vectors_pending.push_back('{x: xc, y: yc});
      vectors_queued++;
   endtask

   task automatic wait_for_drain();
      do @(posedge clock); while (results_seen != vectors_queued);
   endtask

   // Sender: a transaction stays on the port, unchanged, until it is taken.
   always @(negedge clock) begin
      if (sender_calm > 0) sender_calm--;
      else if ($urandom_range(0, 299) == 0) sender_calm = $urandom_range(40, 160);
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (vectors_pending.size() != 0) begin
            req_x_coord <= vectors_pending[0].x;
            req_y_coord <= vectors_pending[0].y;
            req_valid   <= 1'b1;
            void'(vectors_pending.pop_front());
            send_gap = (sender_calm > 0) ? 0 : idle_length();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (receiver_calm > 0) receiver_calm--;
      else if ($urandom_range(0, 299) == 0) receiver_calm = $urandom_range(40, 160);
      if (stall_left == 0 && receiver_calm == 0 && $urandom_range(0, 3) == 0)
         stall_left = idle_length();
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall)
            angles_expected.push_back(clockwise_angle(req_x_coord, req_y_coord));
         if (rsp_valid && !rsp_stall) begin
            if (angles_expected.size() == 0) begin
               $error("rsp_angle_rad: no transaction expected, actual %0d", rsp_angle_rad);
               mismatch_count++;
            end else begin
               angle_due = angles_expected.pop_front();
               if (rsp_angle_rad !== angle_due) begin
                  $error("rsp_angle_rad: expected %0d, actual %0d", angle_due, rsp_angle_rad);
                  mismatch_count++;
               end
               results_seen <= results_seen + 1;
            end
         end
      end
   end

   initial begin
      queue_vector(0, 0);
      queue_vector(0, -5);
      queue_vector(0, 7);
      queue_vector(9, 0);
      queue_vector(-9, 0);
      queue_vector(0, COORD_MIN);
      queue_vector(0, COORD_MAX);
      queue_vector(COORD_MAX, 0);
      queue_vector(COORD_MIN, 0);
      queue_vector(COORD_MAX, COORD_MAX);
      queue_vector(COORD_MIN, COORD_MIN);
      queue_vector(COORD_MAX, COORD_MIN);
      queue_vector(COORD_MIN, COORD_MAX);
      queue_vector(1, 1);
      queue_vector(-1, 1);
      queue_vector(-1, -1);
      queue_vector(1, -1);
      queue_vector(COORD_MAX, 1);
      queue_vector(COORD_MAX, -1);
      queue_vector(COORD_MIN, 1);
      queue_vector(COORD_MIN, -1);
      queue_vector(3, -4);
      queue_vector(-1000, 2000);
      queue_vector(123456, -654321);
      repeat (3) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      wait_for_drain();
      // Each burst is held back until the previous one has fully drained.
      for (int burst = 0; burst < BURST_COUNT; burst++) begin
         for (int n = 0; n < BURST_LENGTH; n++) begin
            vector_type v;
            v = random_vector();
            queue_vector(v.x, v.y);
         end
         wait_for_drain();
      end
      repeat (ITERATIONS + 8) @(posedge clock);
      if (mismatch_count == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule
